[hw/rtl/sgac_pkg.sv]
// Shared types and constants for the stick gesture arming controller.
// Holds the transaction structs, the config register map and the mode codes.
// No dependencies.
package sgac_pkg;

  // Mode codes.
  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_CALIB  = 2'd1;
  localparam logic [1:0] MODE_LOCKED = 2'd2;
  localparam logic [1:0] MODE_ARMED  = 2'd3;

  // Config register indexes.
  localparam logic [2:0] CFG_LOW_VOLTAGE     = 3'd0;
  localparam logic [2:0] CFG_RECOVER_VOLTAGE = 3'd1;
  localparam logic [2:0] CFG_CALIB_THROTTLE  = 3'd2;
  localparam logic [2:0] CFG_LOW_THROTTLE    = 3'd3;
  localparam logic [2:0] CFG_STICK_BOUND     = 3'd4;
  localparam logic [2:0] CFG_ARM_HOLD        = 3'd5;
  localparam logic [2:0] CFG_IDLE_HOLD       = 3'd6;

  // Config reset values.
  localparam logic [15:0] RST_LOW_VOLTAGE     = 16'd10600;
  localparam logic [15:0] RST_RECOVER_VOLTAGE = 16'd11000;
  localparam logic [14:0] RST_CALIB_THROTTLE  = 15'd14746;
  localparam logic [14:0] RST_LOW_THROTTLE    = 15'd1638;
  localparam logic [14:0] RST_STICK_BOUND     = 15'd9830;
  localparam logic [15:0] RST_ARM_HOLD        = 16'd200;
  localparam logic [15:0] RST_IDLE_HOLD       = 16'd1000;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic               link_up;
    logic        [14:0] throttle;
    logic signed [15:0] roll_stick;
    logic signed [15:0] pitch_stick;
    logic signed [15:0] yaw_stick;
    logic        [15:0] battery_mv;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       power_low;
    logic       motor_enable;
    logic       calib_drive;
  } out_item_t;

  typedef struct packed {
    logic [15:0] low_voltage_mv;
    logic [15:0] recover_voltage_mv;
    logic [14:0] calib_throttle;
    logic [14:0] low_throttle;
    logic [14:0] stick_bound;
    logic [15:0] arm_hold;
    logic [15:0] idle_hold;
  } cfg_t;

  // Saturating counter increment.
  function automatic logic [15:0] bump(input logic [15:0] c);
    bump = (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

endpackage

[hw/rtl/sgac_cfg.sv]
// Configuration register file of the arming controller.
// Depends on sgac_pkg for the register map and reset values.
module sgac_cfg import sgac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  // Write one register per enabled cycle; unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_voltage_mv     <= RST_LOW_VOLTAGE;
      cfg.recover_voltage_mv <= RST_RECOVER_VOLTAGE;
      cfg.calib_throttle     <= RST_CALIB_THROTTLE;
      cfg.low_throttle       <= RST_LOW_THROTTLE;
      cfg.stick_bound        <= RST_STICK_BOUND;
      cfg.arm_hold           <= RST_ARM_HOLD;
      cfg.idle_hold          <= RST_IDLE_HOLD;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_LOW_VOLTAGE:     cfg.low_voltage_mv     <= cfg_wdata;
        CFG_RECOVER_VOLTAGE: cfg.recover_voltage_mv <= cfg_wdata;
        CFG_CALIB_THROTTLE:  cfg.calib_throttle     <= cfg_wdata[14:0];
        CFG_LOW_THROTTLE:    cfg.low_throttle       <= cfg_wdata[14:0];
        CFG_STICK_BOUND:     cfg.stick_bound        <= cfg_wdata[14:0];
        CFG_ARM_HOLD:        cfg.arm_hold           <= cfg_wdata;
        CFG_IDLE_HOLD:       cfg.idle_hold          <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/sgac_core.sv]
// Mode machine, power flag and hold counters of the arming controller.
// Computes one tick's result from the registered item; depends on sgac_pkg.
module sgac_core import sgac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result,
  output logic [1:0] mode
);

  logic        low_power;
  logic [15:0] hold_a;
  logic [15:0] hold_b;

  logic        low_power_next;
  logic [1:0]  mode_next;
  logic [15:0] hold_a_next;
  logic [15:0] hold_b_next;
  logic [15:0] hold_a_bump;
  logic [15:0] hold_b_bump;

  logic signed [16:0] bnd_pos;
  logic signed [16:0] bnd_neg;
  logic signed [16:0] roll;
  logic signed [16:0] pitch;
  logic signed [16:0] yaw;
  logic               thr_low;
  logic               arm_gesture;
  logic               disarm_gesture;

  // Stick comparisons at 17 bits so the negated bound always fits.
  assign bnd_pos = $signed({2'b00, cfg.stick_bound});
  assign bnd_neg = -bnd_pos;
  assign roll    = 17'(item.roll_stick);
  assign pitch   = 17'(item.pitch_stick);
  assign yaw     = 17'(item.yaw_stick);
  assign thr_low = item.throttle < cfg.low_throttle;

  assign arm_gesture    = thr_low && (pitch > bnd_pos) && (roll > bnd_pos) && (yaw < bnd_neg);
  assign disarm_gesture = thr_low && (pitch > bnd_pos) && (roll < bnd_neg) && (yaw > bnd_pos);

  assign hold_a_bump = bump(hold_a);
  assign hold_b_bump = bump(hold_b);

  // Battery flag with hysteresis.
  always_comb begin
    if (item.battery_mv < cfg.low_voltage_mv) begin
      low_power_next = 1'b1;
    end else if (item.battery_mv > cfg.recover_voltage_mv) begin
      low_power_next = 1'b0;
    end else begin
      low_power_next = low_power;
    end
  end

  // Mode transitions and hold counters.
  always_comb begin
    mode_next   = mode;
    hold_a_next = hold_a;
    hold_b_next = hold_b;
    unique case (mode)
      MODE_INIT: begin
        if (item.link_up) begin
          mode_next = (item.throttle > cfg.calib_throttle) ? MODE_CALIB : MODE_LOCKED;
        end
      end
      MODE_CALIB: begin
        if (thr_low) begin
          mode_next = MODE_LOCKED;
        end
      end
      MODE_LOCKED: begin
        if (arm_gesture && !low_power_next) begin
          if (hold_a_bump > cfg.arm_hold) begin
            mode_next   = MODE_ARMED;
            hold_a_next = '0;
          end else begin
            hold_a_next = hold_a_bump;
          end
        end else begin
          hold_a_next = '0;
        end
      end
      MODE_ARMED: begin
        // Idle timer and disarm gesture are both checked every tick.
        if (item.throttle == 15'd0) begin
          if (hold_a_bump > cfg.idle_hold) begin
            mode_next   = MODE_LOCKED;
            hold_a_next = '0;
          end else begin
            hold_a_next = hold_a_bump;
          end
        end else begin
          hold_a_next = '0;
        end
        if (disarm_gesture) begin
          if (hold_b_bump > cfg.arm_hold) begin
            mode_next   = MODE_LOCKED;
            hold_b_next = '0;
          end else begin
            hold_b_next = hold_b_bump;
          end
        end else begin
          hold_b_next = '0;
        end
      end
      default: ;
    endcase
  end

  // State advances once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_INIT;
      low_power <= 1'b0;
      hold_a    <= '0;
      hold_b    <= '0;
    end else if (fire) begin
      mode      <= mode_next;
      low_power <= low_power_next;
      hold_a    <= hold_a_next;
      hold_b    <= hold_b_next;
    end
  end

  assign result.mode         = mode_next;
  assign result.power_low    = low_power_next;
  assign result.motor_enable = (mode_next == MODE_ARMED) && item.link_up;
  assign result.calib_drive  = (mode_next == MODE_CALIB) && item.link_up;

endmodule

[hw/rtl/stick_gesture_arming_controller.sv]
// Stick gesture arming controller, top level.
// Instantiates sgac_cfg and sgac_core; depends on sgac_pkg.
//
// Usage: one input transaction per 10 ms tick carries link state, throttle,
// roll, pitch and yaw sticks (Q14) and battery voltage. Each accepted
// transaction yields exactly one output transaction with the mode, the
// low-power flag and the two motor enables, in order.
// Both channels use valid/stall; a transaction moves on a clock edge with
// valid high and stall low.
// The item lands in an input register, and the mode machine and counters
// compute the result into the output register. Throughput is one
// transaction per cycle while the receiver does not stall; the state update
// loop through the mode and counter registers sets this. When the receiver
// stalls, the output register holds its transaction, the input register
// fills, and then in_stall rises until the output drains. Synchronous reset
// returns the mode to initialised, clears the power flag, the counters and
// both pipeline registers, and loads the default config. Config writes take
// effect next cycle; the user must make them while idle (not enforced).
module stick_gesture_arming_controller import sgac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  cfg_t       cfg;
  in_item_t   in_q;
  logic       in_q_valid;
  logic       advance;
  logic       in_accept;
  out_item_t  result;
  logic [1:0] mode;

  sgac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The output stage moves whenever it is empty or being drained.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_q_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  sgac_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (in_q_valid && advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result),
    .mode   (mode)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_q <= in_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q_valid) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // The pipeline only pushes back when the input register is occupied.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("in_stall raised with an empty input register");

  // An accepted transaction is held in the input register next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_q_valid)
    else $error("accepted transaction not captured");

  // The mode never jumps from initialised straight to unlocked.
  a_no_direct_arm: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_INIT) |=> (mode != MODE_ARMED))
    else $error("mode went from initialised to unlocked");

  // Motors are only enabled in a result that reports unlocked.
  a_motor_when_armed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.motor_enable) |-> (out_data.mode == MODE_ARMED))
    else $error("motor enable outside unlocked mode");
`endif

endmodule

[bench/tb.sv]
// Testbench for the stick gesture arming controller.
// Drives random and directed stick ticks, predicts every result and checks it field by field.
// Depends on sgac_pkg and stick_gesture_arming_controller.
`timescale 1ns / 100ps

module tb;
  import sgac_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 100_000;
  localparam int          HOLD_OFF_TICKS = 200;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          PHASE_TICKS    = 155;
  localparam logic [2:0]  CFG_UNUSED     = 3'd7;

  typedef enum {TK_ARM, TK_DISARM, TK_IDLE, TK_NOISE, TK_WILD} tick_shape_e;
  typedef enum {SET_DEEP, SET_ZERO, SET_FULL} setting_e;

  // Predicts the mode machine and compares each output transaction.
  class tick_scoreboard;
    cfg_t        cfg;
    logic [1:0]  mode;
    logic        power_low;
    logic [15:0] arm_idle_cnt;  // arm gesture while locked, zero throttle while unlocked
    logic [15:0] disarm_cnt;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      cfg.low_voltage_mv     = RST_LOW_VOLTAGE;
      cfg.recover_voltage_mv = RST_RECOVER_VOLTAGE;
      cfg.calib_throttle     = RST_CALIB_THROTTLE;
      cfg.low_throttle       = RST_LOW_THROTTLE;
      cfg.stick_bound        = RST_STICK_BOUND;
      cfg.arm_hold           = RST_ARM_HOLD;
      cfg.idle_hold          = RST_IDLE_HOLD;
      mode         = MODE_INIT;
      power_low    = 1'b0;
      arm_idle_cnt = '0;
      disarm_cnt   = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_LOW_VOLTAGE:     cfg.low_voltage_mv     = val;
        CFG_RECOVER_VOLTAGE: cfg.recover_voltage_mv = val;
        CFG_CALIB_THROTTLE:  cfg.calib_throttle     = val[14:0];
        CFG_LOW_THROTTLE:    cfg.low_throttle       = val[14:0];
        CFG_STICK_BOUND:     cfg.stick_bound        = val[14:0];
        CFG_ARM_HOLD:        cfg.arm_hold           = val;
        CFG_IDLE_HOLD:       cfg.idle_hold          = val;
        default: ;
      endcase
    endfunction

    // Steps the predicted state by one accepted tick and queues the expected result.
    function void note_tick(in_item_t t);
      int        bnd, roll, pitch, yaw;
      logic      thr_low;
      out_item_t r;
      bnd     = cfg.stick_bound;
      roll    = $signed(t.roll_stick);
      pitch   = $signed(t.pitch_stick);
      yaw     = $signed(t.yaw_stick);
      thr_low = t.throttle < cfg.low_throttle;

      // Battery flag with hysteresis; the low bound wins.
      if (t.battery_mv < cfg.low_voltage_mv) begin
        power_low = 1'b1;
      end else if (t.battery_mv > cfg.recover_voltage_mv) begin
        power_low = 1'b0;
      end

      case (mode)
        MODE_INIT: begin
          if (t.link_up) begin
            mode = (t.throttle > cfg.calib_throttle) ? MODE_CALIB : MODE_LOCKED;
          end
        end
        MODE_CALIB: begin
          if (thr_low) begin
            mode = MODE_LOCKED;
          end
        end
        MODE_LOCKED: begin
          if (thr_low && pitch > bnd && roll > bnd && yaw < -bnd && !power_low) begin
            if (arm_idle_cnt != COUNT_MAX) arm_idle_cnt++;
            if (arm_idle_cnt > cfg.arm_hold) begin
              mode         = MODE_ARMED;
              arm_idle_cnt = '0;
            end
          end else begin
            arm_idle_cnt = '0;
          end
        end
        default: begin
          // Both disarm paths are looked at in the same tick.
          if (t.throttle == '0) begin
            if (arm_idle_cnt != COUNT_MAX) arm_idle_cnt++;
            if (arm_idle_cnt > cfg.idle_hold) begin
              mode         = MODE_LOCKED;
              arm_idle_cnt = '0;
            end
          end else begin
            arm_idle_cnt = '0;
          end
          if (thr_low && pitch > bnd && roll < -bnd && yaw > bnd) begin
            if (disarm_cnt != COUNT_MAX) disarm_cnt++;
            if (disarm_cnt > cfg.arm_hold) begin
              mode       = MODE_LOCKED;
              disarm_cnt = '0;
            end
          end else begin
            disarm_cnt = '0;
          end
        end
      endcase

      r.mode         = mode;
      r.power_low    = power_low;
      r.motor_enable = (mode == MODE_ARMED) && t.link_up;
      r.calib_drive  = (mode == MODE_CALIB) && t.link_up;
      expected_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report("result transaction with no tick pending");
        return;
      end
      want = expected_q.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("mode got %0d want %0d", got.mode, want.mode));
      if (got.power_low !== want.power_low)
        report($sformatf("power_low got %0b want %0b", got.power_low, want.power_low));
      if (got.motor_enable !== want.motor_enable)
        report($sformatf("motor_enable got %0b want %0b", got.motor_enable,
                         want.motor_enable));
      if (got.calib_drive !== want.calib_drive)
        report($sformatf("calib_drive got %0b want %0b", got.calib_drive,
                         want.calib_drive));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  tick_scoreboard sb;
  bit             hold_off_req;
  bit             sender_gaps_on;
  int             burst_left;
  int unsigned    cycle_count;

  stick_gesture_arming_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Watch both channels at the clock edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_tick(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request.
  initial begin
    int pat_kind, pat_left, pat_step;
    out_stall = 1'b0;
    pat_kind  = 0;
    pat_left  = 0;
    pat_step  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall    = 1'b1;
        repeat (HOLD_OFF_TICKS) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(0, 3);
          pat_left = $urandom_range(8, 64);
        end
        pat_left--;
        pat_step++;
        case (pat_kind)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 1) == 1);
          default: out_stall = (pat_step % 3 == 0);
        endcase
      end
    end
  end

  // Offers one tick and holds it until the block takes it.
  task automatic send_item(in_item_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = t;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every expected result is back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(setting_e which);
    int low_mv;
    case (which)
      SET_ZERO: begin
        write_reg(CFG_LOW_VOLTAGE, 16'd0);
        write_reg(CFG_RECOVER_VOLTAGE, 16'd0);
        write_reg(CFG_CALIB_THROTTLE, 16'd0);
        write_reg(CFG_LOW_THROTTLE, 16'd0);
        write_reg(CFG_STICK_BOUND, 16'd0);
        write_reg(CFG_ARM_HOLD, 16'd0);
        write_reg(CFG_IDLE_HOLD, 16'd0);
      end
      SET_FULL: begin
        write_reg(CFG_LOW_VOLTAGE, 16'hFFFF);
        write_reg(CFG_RECOVER_VOLTAGE, 16'hFFFF);
        write_reg(CFG_CALIB_THROTTLE, 16'd16384);
        write_reg(CFG_LOW_THROTTLE, 16'd16384);
        write_reg(CFG_STICK_BOUND, 16'd16384);
        write_reg(CFG_ARM_HOLD, 16'hFFFF);
        write_reg(CFG_IDLE_HOLD, 16'hFFFF);
      end
      default: begin
        // Short holds so the machine actually arms and disarms.
        low_mv = $urandom_range(9000, 12000);
        write_reg(CFG_LOW_VOLTAGE, 16'(low_mv));
        if ($urandom_range(0, 4) == 0) begin
          write_reg(CFG_RECOVER_VOLTAGE, 16'(low_mv - int'($urandom_range(0, 500))));
        end else begin
          write_reg(CFG_RECOVER_VOLTAGE, 16'(low_mv + int'($urandom_range(0, 1000))));
        end
        write_reg(CFG_CALIB_THROTTLE, 16'($urandom_range(0, 16384)));
        write_reg(CFG_LOW_THROTTLE, 16'($urandom_range(1, 16384)));
        write_reg(CFG_STICK_BOUND, 16'($urandom_range(0, 16384)));
        write_reg(CFG_ARM_HOLD, 16'($urandom_range(0, 6)));
        write_reg(CFG_IDLE_HOLD, 16'($urandom_range(0, 10)));
      end
    endcase
  endtask

  function automatic in_item_t tick(logic link, int thr, int roll, int pitch, int yaw,
                                    int mv);
    in_item_t t;
    t.link_up     = link;
    t.throttle    = 15'(thr);
    t.roll_stick  = 16'(roll);
    t.pitch_stick = 16'(pitch);
    t.yaw_stick   = 16'(yaw);
    t.battery_mv  = 16'(mv);
    return t;
  endfunction

  // Stick value strictly above the bound, now and then out of range.
  function automatic int beyond_pos(int b);
    if (b >= 32767) return 32767;
    if (b < 16384 && $urandom_range(0, 3) != 0) return $urandom_range(16384, b + 1);
    return $urandom_range(32767, b + 1);
  endfunction

  // Stick value strictly below the negated bound.
  function automatic int beyond_neg(int b);
    if (b < 16384 && $urandom_range(0, 3) != 0) return -int'($urandom_range(16384, b + 1));
    return -int'($urandom_range(32768, b + 1));
  endfunction

  function automatic int low_thr();
    if (sb.cfg.low_throttle == 0 || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(sb.cfg.low_throttle - 1, 0);
  endfunction

  // Battery that keeps the power flag clear.
  function automatic int safe_battery();
    int ceiling;
    ceiling = (sb.cfg.low_voltage_mv > sb.cfg.recover_voltage_mv) ?
              sb.cfg.low_voltage_mv : sb.cfg.recover_voltage_mv;
    if (ceiling >= 65535) return 65535;
    return $urandom_range(ceiling + 1, (ceiling < 63535) ? ceiling + 2000 : 65535);
  endfunction

  // Battery around both thresholds, at the rails, or anywhere.
  function automatic int pick_battery();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'(sb.cfg.low_voltage_mv) + int'($urandom_range(0, 128)) - 64;
      1: v = int'(sb.cfg.recover_voltage_mv) + int'($urandom_range(0, 128)) - 64;
      2: v = 0;
      3: v = 65535;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic in_item_t make_tick(tick_shape_e shape);
    in_item_t    t;
    logic [95:0] raw;
    int          b;
    b = sb.cfg.stick_bound;
    t.link_up     = ($urandom_range(0, 7) != 0);
    t.throttle    = 15'($urandom_range(0, 16384));
    t.roll_stick  = 16'(int'($urandom_range(0, 32768)) - 16384);
    t.pitch_stick = 16'(int'($urandom_range(0, 32768)) - 16384);
    t.yaw_stick   = 16'(int'($urandom_range(0, 32768)) - 16384);
    t.battery_mv  = 16'(pick_battery());
    case (shape)
      TK_ARM: begin
        t.throttle    = 15'(low_thr());
        t.roll_stick  = 16'(beyond_pos(b));
        t.pitch_stick = 16'(beyond_pos(b));
        t.yaw_stick   = 16'(beyond_neg(b));
        if ($urandom_range(0, 7) != 0) t.battery_mv = 16'(safe_battery());
      end
      TK_DISARM: begin
        t.throttle    = 15'(low_thr());
        t.roll_stick  = 16'(beyond_neg(b));
        t.pitch_stick = 16'(beyond_pos(b));
        t.yaw_stick   = 16'(beyond_pos(b));
      end
      TK_IDLE: t.throttle = '0;
      TK_WILD: begin
        raw = {$urandom, $urandom, $urandom};
        t   = raw[$bits(in_item_t)-1:0];
      end
      default: ;
    endcase
    return t;
  endfunction

  // Ticks needed to get past a hold, sometimes cut short; long holds always get a short run.
  function automatic int hold_len(logic [15:0] h);
    if (h >= 24) return $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, h + 1);
    return h + 1 + $urandom_range(0, 2);
  endfunction

  // Mostly well-formed gesture holds with random content, plus noise.
  task automatic run_random_phase(int n_ticks);
    int          sent, len, brk;
    tick_shape_e shape;
    sent = 0;
    while (sent < n_ticks) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          shape = TK_ARM;
          len   = hold_len(sb.cfg.arm_hold);
        end
        3, 4: begin
          shape = TK_DISARM;
          len   = hold_len(sb.cfg.arm_hold);
        end
        5: begin
          shape = TK_IDLE;
          len   = hold_len(sb.cfg.idle_hold);
        end
        6, 7, 8: begin
          shape = TK_NOISE;
          len   = $urandom_range(1, 6);
        end
        default: begin
          shape = TK_WILD;
          len   = $urandom_range(1, 3);
        end
      endcase
      // A broken sequence loses the gesture on one tick.
      brk = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        send_item(make_tick((i == brk) ? TK_NOISE : shape));
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    setting_e plan[RANDOM_PHASES];
    plan = '{SET_DEEP, SET_ZERO, SET_DEEP, SET_FULL, SET_DEEP, SET_DEEP, SET_DEEP,
             SET_DEEP};
    sb             = new();
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    hold_off_req   = 1'b0;
    sender_gaps_on = 1'b1;
    burst_left     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Start-up path at reset config: link down, calibration, locked.
    send_item(tick(1'b0, 16384, 0, 0, 0, 0));
    send_item(tick(1'b0, 0, 0, 0, 0, 10800));
    send_item(tick(1'b1, 16384, 0, 0, 0, 65535));
    send_item(tick(1'b0, 16384, 0, 0, 0, 11000));
    send_item(tick(1'b1, 1638, 0, 0, 0, 10600));
    send_item(tick(1'b1, 1637, 0, 0, 0, 10599));
    // Arm gesture blocked by low power, out-of-range sticks, stick at the bound.
    send_item(tick(1'b1, 0, 16384, 16384, -16384, 10599));
    send_item(tick(1'b1, 32767, 32767, -32768, 32767, 11001));
    send_item(tick(1'b1, 0, 9830, 16384, -16384, 12000));
    drain();

    write_reg(CFG_ARM_HOLD, 16'd1);
    write_reg(CFG_IDLE_HOLD, 16'd1);
    write_reg(CFG_UNUSED, 16'hFFFF);
    // Arm, then zero throttle and disarm in the same tick; the disarm count stays.
    send_item(tick(1'b1, 0, 16384, 16384, -16384, 12000));
    send_item(tick(1'b1, 0, 16384, 16384, -16384, 12000));
    send_item(tick(1'b0, 0, 0, 0, 0, 12000));
    send_item(tick(1'b1, 0, -9831, 9831, 9831, 12000));
    send_item(tick(1'b1, 0, 16384, 16384, -16384, 12000));
    send_item(tick(1'b1, 0, 16384, 16384, -16384, 12000));
    // The kept disarm count fires after one more tick.
    send_item(tick(1'b1, 1, -16384, 16384, 16384, 12000));
    send_item(tick(1'b1, 0, 16384, 16384, -16384, 12000));
    send_item(tick(1'b1, 0, 16384, 16384, -16384, 12000));
    // Both disarm paths fire together.
    send_item(tick(1'b1, 0, -16384, 16384, 16384, 12000));
    send_item(tick(1'b1, 0, -16384, 16384, 16384, 12000));
    send_item(tick(1'b1, 16384, 16384, 16384, -16384, 12000));
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(plan[p]);
      if (p == 0) hold_off_req = 1'b1;
      run_random_phase(PHASE_TICKS);
      drain();
    end

    if (sb.expected_q.size() != 0) sb.report("ticks left without a result");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
